>>> hdl/cbor_tir_pkg.sv
package cbor_tir_pkg;

   localparam int DATA_BITS   = 8;
   localparam int FUNC_BITS   = 3;
   localparam int STATUS_BITS = 3;
   localparam int VALUE_BITS  = 64;
   localparam int LEN_BITS    = 16;
   localparam int CNT_BITS    = 4;

   typedef enum logic [FUNC_BITS-1:0] {
      FN_MAP   = 3'd0,
      FN_UINT  = 3'd1,
      FN_INT   = 3'd2,
      FN_BOOL  = 3'd3,
      FN_BYTES = 3'd4,
      FN_TEXT  = 3'd5
   } func_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK        = 3'd0,
      ST_MAJOR     = 3'd1,
      ST_INFO      = 3'd2,
      ST_TRUNC     = 3'd3,
      ST_NONCANON  = 3'd4,
      ST_RANGE     = 3'd5,
      ST_LENGTH    = 3'd6,
      ST_TEXT_LONG = 3'd7
   } status_type;

   localparam logic [2:0] MT_UINT   = 3'd0;
   localparam logic [2:0] MT_NINT   = 3'd1;
   localparam logic [2:0] MT_BYTES  = 3'd2;
   localparam logic [2:0] MT_TEXT   = 3'd3;
   localparam logic [2:0] MT_MAP    = 3'd5;
   localparam logic [2:0] MT_SIMPLE = 3'd7;

   localparam logic [4:0] AI_ARG_MIN = 5'd24;
   localparam logic [4:0] AI_ARG_MAX = 5'd27;

   localparam logic [DATA_BITS-1:0] BYTE_TRUE  = 8'hf5;
   localparam logic [DATA_BITS-1:0] BYTE_FALSE = 8'hf4;

   localparam logic [LEN_BITS-1:0] CAPACITY_RESET = 16'd64;

   localparam logic [0:0] CSR_BUFFER_LENGTH = 1'b0;
   localparam logic [0:0] CSR_TEXT_CAPACITY = 1'b1;

endpackage

>>> hdl/cbor_typed_item_reader_core.sv
// Typed CBOR item reader. The buffer arrives one byte per req_ transfer; on an item's
// first byte req_func names the expected read (map, uint, int, bool, byte string, text).
// The core checks major type, additional info, truncation against buffer_length and
// shortest encoding, gathers 1/2/4/8 argument bytes, applies range and length limits and
// then forwards string payload bytes with rsp_last on the final one. At most one rsp_
// transfer results from each byte; head bytes with an extended argument and all argument
// bytes but the last produce none. All decoding sits between the state registers and the
// response register, so a byte is taken every cycle while the response register is empty
// or being drained. On an error the position returns to the item's start. The user must
// write registers through csr_ only while the core is idle; the core does not enforce it.
module cbor_typed_item_reader_core #(
   parameter int POSITION_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [cbor_tir_pkg::DATA_BITS-1:0]     req_data_byte,
   input  logic [cbor_tir_pkg::FUNC_BITS-1:0]     req_func,
   input  logic                                   req_new_buffer,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [cbor_tir_pkg::STATUS_BITS-1:0]   rsp_status,
   output logic                                   rsp_kind,
   output logic [cbor_tir_pkg::VALUE_BITS-1:0]    rsp_value,
   output logic [cbor_tir_pkg::DATA_BITS-1:0]     rsp_payload_byte,
   output logic                                   rsp_last,
   output logic [cbor_tir_pkg::LEN_BITS-1:0]      rsp_position,
   output logic                                   rsp_at_end,
   input  logic                                   csr_write_enable,
   input  logic [0:0]                             csr_index,
   input  logic [cbor_tir_pkg::LEN_BITS-1:0]      csr_write_data
);
   import cbor_tir_pkg::*;

   localparam int CW = (POSITION_BITS > LEN_BITS) ? POSITION_BITS : LEN_BITS;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_ARGS,
      PH_PAYLOAD
   } phase_type;

   logic [LEN_BITS-1:0]      blen_ff, cap_ff;
   phase_type                phase_ff, phase_in;
   logic [FUNC_BITS-1:0]     rr_ff, rr_in;
   logic [VALUE_BITS-1:0]    arg_ff, arg_in;
   logic [CNT_BITS-1:0]      abl_ff, abl_in;
   logic [CNT_BITS-1:0]      asz_ff, asz_in;
   logic                     neg_ff, neg_in;
   logic [LEN_BITS-1:0]      pl_ff, pl_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] start_ff, start_in;

   logic                     rsp_valid_ff;
   logic [STATUS_BITS-1:0]   rsp_status_ff, res_status;
   logic                     rsp_kind_ff, res_kind;
   logic [VALUE_BITS-1:0]    rsp_value_ff, res_value;
   logic [DATA_BITS-1:0]     rsp_pb_ff, res_pb;
   logic                     rsp_last_ff, res_last;
   logic [LEN_BITS-1:0]      rsp_pos_ff, res_pos;
   logic                     rsp_at_end_ff, res_at_end;
   logic                     res_go;

   logic                     accept;
   phase_type                phase_eff;
   logic [POSITION_BITS-1:0] pos_eff, pos_inc;
   logic [CW-1:0]            pos_eff_x, pos_n_x, blen_x;
   logic [CW:0]              head_end;
   logic [2:0]               major;
   logic [4:0]               ai;
   logic [CNT_BITS-1:0]      extra, abl_dec;
   logic [LEN_BITS-1:0]      pl_dec, rem;
   logic                     major_ok, short_arg;
   logic                     fin_go, fail_go;
   logic [STATUS_BITS-1:0]   fail_st;
   logic [VALUE_BITS-1:0]    fin_u;
   logic [FUNC_BITS-1:0]     fin_rr;
   logic                     fin_neg;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign phase_eff = req_new_buffer ? PH_IDLE : phase_ff;
   assign pos_eff   = req_new_buffer ? '0 : pos_ff;
   assign pos_inc   = pos_eff + POSITION_BITS'(1);
   assign pos_eff_x = CW'(pos_eff);
   assign blen_x    = CW'(blen_ff);
   assign major     = req_data_byte[7:5];
   assign ai        = req_data_byte[4:0];
   assign extra     = CNT_BITS'(1) << ai[1:0];
   assign head_end  = {1'b0, pos_eff_x} + (CW+1)'(1) + (CW+1)'(extra);
   assign abl_dec   = (abl_ff != '0) ? abl_ff - CNT_BITS'(1) : '0;
   assign pl_dec    = (pl_ff != '0) ? pl_ff - LEN_BITS'(1) : '0;

   always_comb begin
      phase_in   = phase_eff;
      rr_in      = rr_ff;
      arg_in     = arg_ff;
      abl_in     = abl_ff;
      asz_in     = asz_ff;
      neg_in     = neg_ff;
      pl_in      = pl_ff;
      pos_in     = pos_eff;
      start_in   = start_ff;
      res_go     = 1'b0;
      res_status = ST_OK;
      res_kind   = 1'b0;
      res_value  = '0;
      res_pb     = '0;
      res_last   = 1'b1;
      fin_go     = 1'b0;
      fin_u      = '0;
      fin_rr     = rr_ff;
      fin_neg    = neg_ff;
      fail_go    = 1'b0;
      fail_st    = ST_OK;
      major_ok   = 1'b0;
      short_arg  = 1'b0;
      rem        = '0;
      pos_n_x    = '0;

      case (phase_eff)
         PH_ARGS: begin
            arg_in = {arg_ff[VALUE_BITS-DATA_BITS-1:0], req_data_byte};
            pos_in = pos_inc;
            abl_in = abl_dec;
            if (abl_dec == '0) begin
               case (asz_ff)
                  4'd1:    short_arg = arg_in < VALUE_BITS'(AI_ARG_MIN);
                  4'd2:    short_arg = arg_in[63:8] == '0;
                  4'd4:    short_arg = arg_in[63:16] == '0;
                  default: short_arg = arg_in[63:32] == '0;
               endcase
               if (short_arg) begin
                  fail_go = 1'b1;
                  fail_st = ST_NONCANON;
               end else begin
                  fin_go = 1'b1;
                  fin_u  = arg_in;
               end
            end
         end
         PH_PAYLOAD: begin
            pos_in   = pos_inc;
            pl_in    = pl_dec;
            res_go   = 1'b1;
            res_kind = 1'b1;
            res_pb   = req_data_byte;
            res_last = pl_dec == '0;
            if (pl_dec == '0) begin
               phase_in = PH_IDLE;
            end
         end
         default: begin
            start_in = pos_eff;
            rr_in    = req_func;
            neg_in   = 1'b0;
            case (req_func)
               FN_MAP:   major_ok = major == MT_MAP;
               FN_UINT:  major_ok = major == MT_UINT;
               FN_INT: begin
                  major_ok = (major == MT_UINT) || (major == MT_NINT);
                  neg_in   = major == MT_NINT;
               end
               FN_BYTES: major_ok = major == MT_BYTES;
               FN_TEXT:  major_ok = major == MT_TEXT;
               default:  major_ok = 1'b0;
            endcase
            if (pos_eff_x >= blen_x) begin
               fail_go = 1'b1;
               fail_st = ST_TRUNC;
            end else if (req_func == FN_BOOL) begin
               if (req_data_byte == BYTE_TRUE || req_data_byte == BYTE_FALSE) begin
                  pos_in    = pos_inc;
                  res_go    = 1'b1;
                  res_value = VALUE_BITS'(req_data_byte == BYTE_TRUE);
               end else begin
                  fail_go = 1'b1;
                  fail_st = (major == MT_SIMPLE) ? ST_INFO : ST_MAJOR;
               end
            end else if (!major_ok) begin
               fail_go = 1'b1;
               fail_st = ST_MAJOR;
            end else if (ai < AI_ARG_MIN) begin
               pos_in  = pos_inc;
               fin_go  = 1'b1;
               fin_u   = VALUE_BITS'(ai);
               fin_rr  = req_func;
               fin_neg = neg_in;
            end else if (ai > AI_ARG_MAX) begin
               fail_go = 1'b1;
               fail_st = ST_INFO;
            end else if (head_end > {1'b0, blen_x}) begin
               fail_go = 1'b1;
               fail_st = ST_TRUNC;
            end else begin
               pos_in   = pos_inc;
               arg_in   = '0;
               abl_in   = extra;
               asz_in   = extra;
               phase_in = PH_ARGS;
            end
         end
      endcase

      if (fin_go) begin
         phase_in = PH_IDLE;
         res_go   = 1'b1;
         pos_n_x  = CW'(pos_in);
         if (pos_n_x < blen_x) begin
            rem = blen_ff - pos_n_x[LEN_BITS-1:0];
         end
         case (fin_rr)
            FN_MAP: begin
               if (fin_u[63:32] != '0) begin
                  fail_go = 1'b1;
                  fail_st = ST_RANGE;
               end else begin
                  res_value = fin_u;
               end
            end
            FN_UINT: res_value = fin_u;
            FN_INT: begin
               if (fin_u[63]) begin
                  fail_go = 1'b1;
                  fail_st = ST_RANGE;
               end else begin
                  res_value = fin_neg ? ~fin_u : fin_u;
               end
            end
            default: begin
               if (fin_u > VALUE_BITS'(rem)) begin
                  fail_go = 1'b1;
                  fail_st = ST_LENGTH;
               end else if (fin_rr == FN_TEXT && fin_u >= VALUE_BITS'(cap_ff)) begin
                  fail_go = 1'b1;
                  fail_st = ST_TEXT_LONG;
               end else if (fin_u != '0) begin
                  res_value = fin_u;
                  res_last  = 1'b0;
                  pl_in     = fin_u[LEN_BITS-1:0];
                  phase_in  = PH_PAYLOAD;
               end
            end
         endcase
      end

      if (fail_go) begin
         pos_in     = start_in;
         phase_in   = PH_IDLE;
         abl_in     = '0;
         pl_in      = '0;
         res_go     = 1'b1;
         res_status = fail_st;
         res_kind   = 1'b0;
         res_value  = '0;
         res_pb     = '0;
         res_last   = 1'b1;
      end

      res_pos    = LEN_BITS'(CW'(pos_in));
      res_at_end = CW'(pos_in) == blen_x;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blen_ff      <= '0;
         cap_ff       <= CAPACITY_RESET;
         phase_ff     <= PH_IDLE;
         rr_ff        <= '0;
         arg_ff       <= '0;
         abl_ff       <= '0;
         asz_ff       <= '0;
         neg_ff       <= 1'b0;
         pl_ff        <= '0;
         pos_ff       <= '0;
         start_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_BUFFER_LENGTH: blen_ff <= csr_write_data;
               CSR_TEXT_CAPACITY: cap_ff  <= csr_write_data;
               default:           blen_ff <= blen_ff;
            endcase
         end
         if (accept) begin
            phase_ff <= phase_in;
            rr_ff    <= rr_in;
            arg_ff   <= arg_in;
            abl_ff   <= abl_in;
            asz_ff   <= asz_in;
            neg_ff   <= neg_in;
            pl_ff    <= pl_in;
            pos_ff   <= pos_in;
            start_ff <= start_in;
         end
         if (accept && res_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && res_go) begin
         rsp_status_ff <= res_status;
         rsp_kind_ff   <= res_kind;
         rsp_value_ff  <= res_value;
         rsp_pb_ff     <= res_pb;
         rsp_last_ff   <= res_last;
         rsp_pos_ff    <= res_pos;
         rsp_at_end_ff <= res_at_end;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_value        = rsp_value_ff;
   assign rsp_payload_byte = rsp_pb_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_position     = rsp_pos_ff;
   assign rsp_at_end       = rsp_at_end_ff;

   a_args_pending: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_ARGS |-> abl_ff != '0 && $onehot(asz_ff) && abl_ff <= asz_ff)
      else $error("argument counter out of step");

   a_payload_pending: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> pl_ff != '0)
      else $error("payload phase with nothing left");

   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != ST_OK |->
         rsp_last_ff && rsp_value_ff == '0 && !rsp_kind_ff)
      else $error("error response not final or carries data");

   a_payload_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff |-> rsp_status_ff == ST_OK && rsp_value_ff == '0)
      else $error("payload response with status or value");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !req_ready)
      else $error("input taken while response stalled");

endmodule
